/* hdl/xkh_pkg.sv */
// Shared types, constants and the xorshift mixing function for the key hash block.
// No dependencies; every other file imports this package.
package xkh_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned BytesW = 3;
  localparam int unsigned NumBytes = WordW / 8;
  localparam int unsigned CntW   = $clog2(WordW);

  localparam logic [WordW-1:0]  MixConst    = 32'h031b_5515;
  localparam logic [WordW-1:0]  BucketReset = 32'd1024;
  localparam logic [CntW-1:0]   LastStep    = CntW'(WordW - 1);
  localparam logic [BytesW-1:0] FullBytes   = BytesW'(NumBytes);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } xkh_state_e;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] rem;
  } xkh_div_sts_t;

  function automatic logic [WordW-1:0] xs_mix(input logic [WordW-1:0] w);
    logic [WordW-1:0] t;
    t = w ^ MixConst;
    t = t ^ (t << 13);
    t = t ^ (t >> 7);
    t = t ^ (t << 17);
    return t;
  endfunction

  // Keeps bytes below the valid count; counts above four act as four.
  function automatic logic [WordW-1:0] byte_mask(input logic [BytesW-1:0] nb);
    logic [WordW-1:0]  m;
    logic [BytesW-1:0] n;
    n = (nb > FullBytes) ? FullBytes : nb;
    for (int k = 0; k < NumBytes; k++) begin
      m[k*8 +: 8] = (BytesW'(k) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

/* hdl/xkh_if.sv */
// Valid/ready channel interfaces for key chunk requests and hash results.
// Depends on xkh_pkg.
interface xkh_req_if
  import xkh_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [WordW-1:0]  chunk_word;
  logic [BytesW-1:0] bytes_valid;
  logic              last_chunk;

  modport source (output valid, chunk_word, bytes_valid, last_chunk, input ready);
  modport sink   (input valid, chunk_word, bytes_valid, last_chunk, output ready);
endinterface

interface xkh_res_if
  import xkh_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] key_hash;
  logic [WordW-1:0] bucket_index;

  modport source (output valid, key_hash, bucket_index, input ready);
  modport sink   (input valid, key_hash, bucket_index, output ready);
endinterface

/* hdl/xkh_acc.sv */
// Running hash: masks each chunk, applies the xorshift mix and folds it in.
// Depends on xkh_pkg.
module xkh_acc
  import xkh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [WordW-1:0]  chunk_word_i,
  input  logic [BytesW-1:0] bytes_valid_i,
  input  logic              last_chunk_i,
  output logic [WordW-1:0]  hash_o
);

  logic [WordW-1:0] run_q, run_d;
  logic [WordW-1:0] mixed;

  always_comb begin
    mixed  = xs_mix(chunk_word_i & byte_mask(bytes_valid_i));
    hash_o = (bytes_valid_i == '0) ? run_q : (run_q ^ mixed);
    run_d  = run_q;
    if (en_i) begin
      run_d = last_chunk_i ? '0 : hash_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else begin
      run_q <= run_d;
    end
  end

endmodule

/* hdl/xkh_mod.sv */
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on xkh_pkg.
module xkh_mod
  import xkh_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WordW-1:0] dividend_i,
  input  logic [WordW-1:0] divisor_i,
  output xkh_div_sts_t     sts_o
);

  logic [WordW-1:0] rem_q, rem_d;
  logic [WordW-1:0] dvd_q, dvd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [WordW:0]   trial;

  always_comb begin
    trial  = {rem_q, dvd_q[WordW-1]};
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = done_q;
    if (start_i) begin
      rem_d  = '0;
      dvd_d  = dividend_i;
      cnt_d  = '0;
      run_d  = 1'b1;
      done_d = 1'b0;
    end else if (run_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = WordW'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[WordW-1:0];
      end
      dvd_d = {dvd_q[WordW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign sts_o.done = done_q;
  assign sts_o.rem  = rem_q;

endmodule

/* hdl/xorshift_key_hash_bucket_index.sv */
// Key hash and bucket index, top level: FSM, bucket count register, result register.
// Depends on xkh_pkg, xkh_if, xkh_acc and xkh_mod.
//
// Keys arrive as 32-bit little-endian chunk requests. A chunk that is not last is folded
// into the running xorshift hash. A last chunk starts a bit-serial remainder by the bucket
// count, one step per hash bit; the next request is taken only once the remainder is done
// and the result register is free. A finished result sits in an output register, so a
// following key can be hashed while it waits. Bucket count 0 returns the hash as the index.
module xorshift_key_hash_bucket_index
  import xkh_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  xkh_req_if.sink          req_i,
  xkh_res_if.source        res_o,
  input  logic             cfg_we_i,
  input  logic [WordW-1:0] cfg_wdata_i
);

  xkh_state_e       state_q, state_d;
  logic [WordW-1:0] bucket_count_q;
  logic [WordW-1:0] hash_q;
  logic [WordW-1:0] hash_now;
  logic             out_valid_q;
  logic [WordW-1:0] out_hash_q;
  logic [WordW-1:0] out_index_q;
  logic             req_acc;
  logic             div_start;
  logic             out_free;
  logic             out_load;
  xkh_div_sts_t     div_sts;

  assign req_acc  = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || res_o.ready;

  xkh_acc u_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (req_acc),
    .chunk_word_i (req_i.chunk_word),
    .bytes_valid_i(req_i.bytes_valid),
    .last_chunk_i (req_i.last_chunk),
    .hash_o       (hash_now)
  );

  xkh_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(hash_now),
    .divisor_i (bucket_count_q),
    .sts_o     (div_sts)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_acc && req_i.last_chunk) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        div_start   = req_acc && req_i.last_chunk;
      end
      ST_DIV: begin
        out_load = div_sts.done && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      bucket_count_q <= BucketReset;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        bucket_count_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      hash_q <= hash_now;
    end
    if (out_load) begin
      out_hash_q  <= hash_q;
      out_index_q <= (bucket_count_q == '0) ? hash_q : div_sts.rem;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.key_hash     = out_hash_q;
  assign res_o.bucket_index = out_index_q;

`ifndef ASSERT_OFF
  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && bucket_count_q != '0) |-> (div_sts.rem < bucket_count_q))
    else $error("remainder not below bucket count");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(div_sts.done) |-> (state_q == ST_DIV))
    else $error("divider finished outside of a division");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result load did not show a result");
`endif

endmodule

/* dv/xorshift_key_hash_bucket_index_test.sv */
// Self-checking testbench for xorshift_key_hash_bucket_index: directed rows, then random keys.
// Predicts hash and bucket index per key; depends on xkh_pkg, xkh_if and the block's RTL.
module xorshift_key_hash_bucket_index_test
  import xkh_pkg::*;
();

  localparam logic [WordW-1:0] KeyMix      = 32'h031b_5515;
  localparam int unsigned      DrainCycles = 40;
  localparam int unsigned      RandPhases  = 8;
  localparam int unsigned      PhaseChunks = 130;

  typedef enum logic {
    ROW_CHUNK,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [WordW-1:0]  word;
    logic [BytesW-1:0] nb;
    logic              is_last;
    logic              typed;
    logic [WordW-1:0]  want_hash;
    logic [WordW-1:0]  want_index;
  } stim_row_t;

  typedef struct packed {
    logic [WordW-1:0] key_hash;
    logic [WordW-1:0] bucket_index;
  } hash_result_t;

  localparam int unsigned NumRows = 24;
  localparam stim_row_t DIRECTED [NumRows] = '{
    '{ROW_CHUNK, 32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0, 32'h0},  // empty key after reset
    '{ROW_CHUNK, 32'hffff_ffff, 3'd4, 1'b1, 1'b0, 32'h0, 32'h0},
    '{ROW_CHUNK, 32'h0000_0000, 3'd4, 1'b1, 1'b0, 32'h0, 32'h0},
    '{ROW_CHUNK, 32'hffff_ffff, 3'd7, 1'b1, 1'b0, 32'h0, 32'h0},  // too many bytes
    '{ROW_CHUNK, 32'hffff_ffff, 3'd5, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_CHUNK, 32'hffff_ffff, 3'd6, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_CHUNK, 32'hffff_ffff, 3'd3, 1'b1, 1'b0, 32'h0, 32'h0},  // stray high bytes
    '{ROW_CHUNK, 32'hdead_beef, 3'd1, 1'b1, 1'b0, 32'h0, 32'h0},
    '{ROW_CHUNK, 32'ha5a5_a5a5, 3'd2, 1'b1, 1'b0, 32'h0, 32'h0},
    '{ROW_CHUNK, 32'h5a5a_5a5a, 3'd2, 1'b0, 1'b0, 32'h0, 32'h0},  // short chunk mid-key
    '{ROW_CHUNK, 32'h0bad_f00d, 3'd4, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_CHUNK, 32'h0000_0000, 3'd0, 1'b1, 1'b0, 32'h0, 32'h0},
    '{ROW_CHUNK, 32'hffff_ffff, 3'd0, 1'b0, 1'b0, 32'h0, 32'h0},  // empty chunk mid-key
    '{ROW_CHUNK, 32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0, 32'h0},
    '{ROW_CFG,   32'h0000_0000, 3'd0, 1'b0, 1'b0, 32'h0, 32'h0},  // zero bucket count
    '{ROW_CHUNK, 32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0, 32'h0},
    '{ROW_CHUNK, 32'h1234_5678, 3'd4, 1'b1, 1'b0, 32'h0, 32'h0},
    '{ROW_CFG,   32'h0000_0001, 3'd0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_CHUNK, 32'hcafe_f00d, 3'd4, 1'b1, 1'b0, 32'h0, 32'h0},
    '{ROW_CFG,   32'hffff_ffff, 3'd0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_CHUNK, 32'hffff_ffff, 3'd4, 1'b1, 1'b0, 32'h0, 32'h0},
    '{ROW_CHUNK, 32'h00ff_ffff, 3'd3, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_CHUNK, 32'h8000_0000, 3'd4, 1'b1, 1'b0, 32'h0, 32'h0},
    '{ROW_CFG,   32'h0000_0400, 3'd0, 1'b0, 1'b0, 32'h0, 32'h0}
  };

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [WordW-1:0] cfg_wdata;

  xkh_req_if chunk_req ();
  xkh_res_if hash_res ();

  xorshift_key_hash_bucket_index i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (chunk_req),
    .res_o      (hash_res),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [WordW-1:0] model_hash;
  logic [WordW-1:0] model_buckets;
  hash_result_t     pending_results[$];
  int unsigned      mismatches;
  int unsigned      chunks_sent;
  bit               src_steady;

  function automatic logic [WordW-1:0] mixed_chunk(input logic [WordW-1:0] w,
                                                   input logic [BytesW-1:0] nb);
    logic [WordW-1:0] t;
    int unsigned      n;
    n = (nb > 3'd4) ? 4 : int'(nb);
    t = (n == 4) ? w : (w & ((32'd1 << (8 * n)) - 32'd1));
    t = t ^ KeyMix;
    t = t ^ (t << 13);
    t = t ^ (t >> 7);
    t = t ^ (t << 17);
    return t;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Drives one chunk request, waits for its handshake and, for a last chunk, records the expected result.
  task automatic send_chunk(input logic [WordW-1:0] w, input logic [BytesW-1:0] nb,
                            input logic is_last, input logic typed = 1'b0,
                            input logic [WordW-1:0] want_hash = '0,
                            input logic [WordW-1:0] want_index = '0);
    int unsigned  gap;
    hash_result_t r;
    if ($urandom_range(0, 49) == 0) src_steady = !src_steady;
    gap = src_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      chunk_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chunk_req.valid       <= 1'b1;
    chunk_req.chunk_word  <= w;
    chunk_req.bytes_valid <= nb;
    chunk_req.last_chunk  <= is_last;
    @(posedge clk);
    while (!chunk_req.ready) @(posedge clk);
    chunks_sent++;
    if (nb != '0) model_hash = model_hash ^ mixed_chunk(w, nb);
    if (is_last) begin
      r.key_hash     = model_hash;
      r.bucket_index = (model_buckets == '0) ? model_hash : model_hash % model_buckets;
      model_hash     = '0;
      if (typed) begin
        r.key_hash     = want_hash;
        r.bucket_index = want_index;
      end
      pending_results.push_back(r);
    end
  endtask

  task automatic wait_idle();
    chunk_req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_buckets(input logic [WordW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we        <= 1'b0;
    model_buckets = v;
  endtask

  // Mostly well-formed keys with random content; the rest is random chunk noise.
  task automatic send_key();
    int unsigned      len;
    int unsigned      n;
    bit               garbage;
    bit               empty_tail;
    logic [WordW-1:0] w;
    if ($urandom_range(0, 6) == 0) begin
      send_chunk($urandom, BytesW'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    end else begin
      len        = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 16);
      garbage    = 1'($urandom_range(0, 1));
      empty_tail = (len == 0) || ($urandom_range(0, 4) == 0);
      while (len > 0) begin
        n   = (len > 4) ? 4 : len;
        len = len - n;
        w   = $urandom;
        if (!garbage && n < 4) w = w & ((32'd1 << (8 * n)) - 32'd1);
        send_chunk(w, BytesW'(n), (len == 0) && !empty_tail);
      end
      if (empty_tail) send_chunk(garbage ? $urandom : '0, '0, 1'b1);
    end
  endtask

  initial begin
    logic [WordW-1:0] v;
    int unsigned      target;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_wdata             <= '0;
    chunk_req.valid       <= 1'b0;
    chunk_req.chunk_word  <= '0;
    chunk_req.bytes_valid <= '0;
    chunk_req.last_chunk  <= 1'b0;
    model_hash    = '0;
    model_buckets = BucketReset;
    mismatches    = 0;
    chunks_sent   = 0;
    src_steady    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumRows; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        wait_idle();
        write_buckets(DIRECTED[i].word);
      end else begin
        send_chunk(DIRECTED[i].word, DIRECTED[i].nb, DIRECTED[i].is_last,
                   DIRECTED[i].typed, DIRECTED[i].want_hash, DIRECTED[i].want_index);
      end
    end

    target = chunks_sent;
    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0:       v = 32'd0;
        1:       v = 32'd1;
        2:       v = 32'hffff_ffff;
        3:       v = 32'd7;
        4:       v = 32'd1 << $urandom_range(0, 31);
        5:       v = $urandom_range(2, 1000);
        6:       v = 32'hffff_fffe;
        default: v = $urandom;
      endcase
      wait_idle();
      write_buckets(v);
      target = target + PhaseChunks;
      while (chunks_sent < target) send_key();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("xorshift_key_hash_bucket_index_test passed");
    end else begin
      $display("xorshift_key_hash_bucket_index_test failed");
    end
    $finish;
  end

  initial begin
    int unsigned  gap;
    bit           steady;
    hash_result_t want;
    steady = 1'b0;
    hash_res.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) steady = !steady;
      gap = steady ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        hash_res.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      hash_res.ready <= 1'b1;
      @(posedge clk);
      while (!hash_res.valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result hash %h index %h",
                                  hash_res.key_hash, hash_res.bucket_index));
      end else begin
        want = pending_results.pop_front();
        if (hash_res.key_hash !== want.key_hash)
          report_mismatch($sformatf("key_hash %h, want %h", hash_res.key_hash, want.key_hash));
        if (hash_res.bucket_index !== want.bucket_index)
          report_mismatch($sformatf("bucket_index %h, want %h",
                                    hash_res.bucket_index, want.bucket_index));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("xorshift_key_hash_bucket_index_test failed");
    $finish;
  end

endmodule
